// File: rtl/ppl_pkg.sv
// Shared types and constants for the positional point list.
// Holds request and status codes, the cell control struct and default sizes.
`default_nettype none

package ppl_pkg;

    localparam int DEF_CAPACITY    = 64;
    localparam int DEF_COORD_WIDTH = 16;

    localparam int REQ_W    = 3;
    localparam int POS_W    = 7;
    localparam int PT_W     = 16;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;

    typedef enum logic [REQ_W-1:0] {
        REQ_APPEND = 3'd0,
        REQ_INSERT = 3'd1,
        REQ_REMOVE = 3'd2,
        REQ_CLEAR  = 3'd3,
        REQ_READ   = 3'd4
    } t_req_type;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_DONE    = 2'd0,
        STATUS_BAD_POS = 2'd1,
        STATUS_FULL    = 2'd2
    } t_status;

    // Per-cycle command broadcast to every cell of the chain.
    typedef struct packed {
        logic wr;          // write the new point at the write position
        logic shift_up;    // cells above the write position take their lower neighbor
        logic shift_down;  // cells at or above the position take their upper neighbor
    } t_cell_ctrl;

endpackage : ppl_pkg

`default_nettype wire

// File: rtl/ppl_cell.sv
// One storage cell of the point list chain.
// Depends on ppl_pkg for the cell control struct.
`default_nettype none

module ppl_cell
    import ppl_pkg::*;
#(
    parameter int INDEX  = 0,
    parameter int CMP_W  = 7,
    parameter int DATA_W = 32
) (
    input  wire logic              i_clk,
    input  wire t_cell_ctrl        i_ctrl,
    input  wire logic [CMP_W-1:0]  i_wpos,
    input  wire logic [CMP_W-1:0]  i_rpos,
    input  wire logic [DATA_W-1:0] i_point,
    input  wire logic [DATA_W-1:0] i_left,
    input  wire logic [DATA_W-1:0] i_right,
    output logic      [DATA_W-1:0] o_data,
    output logic      [DATA_W-1:0] o_rd
);

    localparam logic [CMP_W-1:0] IDX = CMP_W'(INDEX);

    logic [DATA_W-1:0] r_data;
    logic [DATA_W-1:0] n_data;

    always_comb begin
        n_data = r_data;
        if (i_ctrl.wr && (IDX == i_wpos)) begin
            n_data = i_point;
        end else if (i_ctrl.shift_up && (IDX > i_wpos)) begin
            n_data = i_left;
        end else if (i_ctrl.shift_down && (IDX >= i_wpos)) begin
            n_data = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;
    // Only the addressed cell drives the shared read bus.
    assign o_rd   = (IDX == i_rpos) ? r_data : '0;

endmodule : ppl_cell

`default_nettype wire

// File: rtl/positional_point_list.sv
// Positional point list: an accepted request's result is registered next cycle.
// One request per cycle unless a result stalls; every cell shifts together.
// The output register frees the input side whenever the result is taken or absent.
// Synchronous active-low reset empties the list and drops any pending result.
// Point storage has no reset; only entries below the count are ever read.
`default_nettype none

module positional_point_list
    import ppl_pkg::*;
#(
    parameter int CAPACITY    = DEF_CAPACITY,
    parameter int COORD_WIDTH = DEF_COORD_WIDTH
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // Request channel.
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire logic [REQ_W-1:0]      i_req_type,
    input  wire logic [POS_W-1:0]      i_position,
    input  wire logic signed [PT_W-1:0] i_point_x,
    input  wire logic signed [PT_W-1:0] i_point_y,
    // Result channel.
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output logic [STATUS_W-1:0]        o_status,
    output logic signed [PT_W-1:0]     o_read_x,
    output logic signed [PT_W-1:0]     o_read_y,
    output logic [COUNT_W-1:0]         o_count
);

    // The count can hold CAPACITY itself; positions are compared at the wider
    // of the count width and the request's position width.
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int DATA_W = 2 * COORD_WIDTH;

    localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

    // Count register and output register.
    logic [CNT_W-1:0]          r_count;
    logic [CNT_W-1:0]          n_count;
    logic                      r_valid;
    logic [STATUS_W-1:0]       r_status;
    logic signed [PT_W-1:0]    r_read_x;
    logic signed [PT_W-1:0]    r_read_y;
    logic [COUNT_W-1:0]        r_count_out;

    logic                      w_accept;
    logic [CMP_W-1:0]          w_pos;
    logic [CMP_W-1:0]          w_cnt;
    logic [CMP_W-1:0]          w_wpos;
    logic                      w_full;
    t_cell_ctrl                w_ctrl;
    t_status                   w_status;
    logic                      w_rd_en;

    // Coordinate conversion between the 16-bit ports and the stored width.
    logic signed [31:0]        w_px32;
    logic signed [31:0]        w_py32;
    logic [DATA_W-1:0]         w_point;
    logic [DATA_W-1:0]         w_rd_bus;
    logic signed [COORD_WIDTH-1:0] w_rx;
    logic signed [COORD_WIDTH-1:0] w_ry;
    logic signed [31:0]        w_rx32;
    logic signed [31:0]        w_ry32;
    logic signed [PT_W-1:0]    n_read_x;
    logic signed [PT_W-1:0]    n_read_y;

    logic [DATA_W-1:0]         w_cell_data [CAPACITY];
    logic [DATA_W-1:0]         w_cell_rd   [CAPACITY];

    // A new request is held off only while a finished result is still waiting.
    assign o_stall  = r_valid && i_stall;
    assign w_accept = i_valid && !o_stall;

    assign w_pos  = CMP_W'(i_position);
    assign w_cnt  = CMP_W'(r_count);
    assign w_full = (r_count == CAP_C);

    // Points are sign-extended from the port, then cut to the stored width.
    assign w_px32  = 32'(i_point_x);
    assign w_py32  = 32'(i_point_y);
    assign w_point = {w_py32[COORD_WIDTH-1:0], w_px32[COORD_WIDTH-1:0]};

    // Decode the request into a status, a new count and a cell command.
    // An append is a write at the count with no shifting.
    always_comb begin
        w_status = STATUS_DONE;
        n_count  = r_count;
        w_ctrl   = '0;
        w_wpos   = w_pos;
        w_rd_en  = 1'b0;
        case (t_req_type'(i_req_type))
            REQ_APPEND: begin
                w_wpos = w_cnt;
                if (w_full) begin
                    w_status = STATUS_FULL;
                end else begin
                    w_ctrl.wr = 1'b1;
                    n_count   = r_count + 1'b1;
                end
            end
            REQ_INSERT: begin
                // A bad position is reported ahead of a full list.
                if (w_pos > w_cnt) begin
                    w_status = STATUS_BAD_POS;
                end else if (w_full) begin
                    w_status = STATUS_FULL;
                end else begin
                    w_ctrl.wr       = 1'b1;
                    w_ctrl.shift_up = 1'b1;
                    n_count         = r_count + 1'b1;
                end
            end
            REQ_REMOVE: begin
                if (w_pos >= w_cnt) begin
                    w_status = STATUS_BAD_POS;
                end else begin
                    w_ctrl.shift_down = 1'b1;
                    n_count           = r_count - 1'b1;
                end
            end
            REQ_CLEAR: begin
                n_count = '0;
            end
            REQ_READ: begin
                if (w_pos >= w_cnt) begin
                    w_status = STATUS_BAD_POS;
                end else begin
                    w_rd_en = 1'b1;
                end
            end
            default: begin
                // Unknown request kinds leave everything as it is.
            end
        endcase
        if (!w_accept) begin
            w_ctrl  = '0;
            n_count = r_count;
        end
    end

    // The chain of cells. Cell i takes from cell i-1 on an insert and from
    // cell i+1 on a remove; the ends see a zero neighbor, which only ever
    // lands in entries beyond the count.
    for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
        logic [DATA_W-1:0] w_left;
        logic [DATA_W-1:0] w_right;

        if (gi == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_inner_l
            assign w_left = w_cell_data[gi-1];
        end

        if (gi == CAPACITY - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_inner_r
            assign w_right = w_cell_data[gi+1];
        end

        ppl_cell #(
            .INDEX  (gi),
            .CMP_W  (CMP_W),
            .DATA_W (DATA_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (w_ctrl),
            .i_wpos  (w_wpos),
            .i_rpos  (w_pos),
            .i_point (w_point),
            .i_left  (w_left),
            .i_right (w_right),
            .o_data  (w_cell_data[gi]),
            .o_rd    (w_cell_rd[gi])
        );
    end

    // Each cell gates its own entry onto the read bus, so the bus is an OR
    // of one-hot contributions.
    always_comb begin
        w_rd_bus = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            w_rd_bus = w_rd_bus | w_cell_rd[k];
        end
    end

    // Stored coordinates are sign-extended from their width, then cut to 16 bits.
    assign w_rx   = w_rd_bus[COORD_WIDTH-1:0];
    assign w_ry   = w_rd_bus[DATA_W-1:COORD_WIDTH];
    assign w_rx32 = 32'(w_rx);
    assign w_ry32 = 32'(w_ry);
    assign n_read_x = w_rd_en ? w_rx32[PT_W-1:0] : '0;
    assign n_read_y = w_rd_en ? w_ry32[PT_W-1:0] : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_accept) begin
                r_valid <= 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Result payload loads with each accepted request.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status    <= w_status;
            r_read_x    <= n_read_x;
            r_read_y    <= n_read_y;
            r_count_out <= COUNT_W'(n_count);
        end
    end

    assign o_valid  = r_valid;
    assign o_status = r_status;
    assign o_read_x = r_read_x;
    assign o_read_y = r_read_y;
    assign o_count  = r_count_out;

endmodule : positional_point_list

`default_nettype wire

// File: rtl/ppl_checker.sv
// Port-level checker for the positional point list, bound to the top level.
// Depends on ppl_pkg for request and status codes.
`default_nettype none

module ppl_checker
    import ppl_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_req_valid,
    input  wire logic                i_req_stall,
    input  wire logic [REQ_W-1:0]    i_req_type,
    input  wire logic                i_res_valid,
    input  wire logic                i_res_stall,
    input  wire logic [STATUS_W-1:0] i_status,
    input  wire logic [PT_W-1:0]     i_read_x,
    input  wire logic [PT_W-1:0]     i_read_y,
    input  wire logic [COUNT_W-1:0]  i_count
);

    localparam logic [COUNT_W-1:0] CAP_OUT = COUNT_W'(CAPACITY);

    // A stalled result stays and holds its payload.
    a_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_res_stall |=> i_res_valid && $stable(i_status)
            && $stable(i_read_x) && $stable(i_read_y) && $stable(i_count))
        else $error("stalled result changed");

    // A rejected request reports no point.
    a_reject_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && (i_status != STATUS_DONE) |-> (i_read_x == '0) && (i_read_y == '0))
        else $error("rejected request returned a point");

    // A full report only comes with a full list.
    a_full_count : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && (i_status == STATUS_FULL) |-> (i_count == CAP_OUT))
        else $error("full status with a list that is not full");

    // A clear is answered in the next cycle with an empty list.
    a_clear : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && !i_req_stall && (i_req_type == REQ_CLEAR)
            |=> i_res_valid && (i_count == '0) && (i_status == STATUS_DONE))
        else $error("clear did not empty the list");

endmodule : ppl_checker

bind positional_point_list ppl_checker #(
    .CAPACITY (CAPACITY)
) u_ppl_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_valid),
    .i_req_stall (o_stall),
    .i_req_type  (i_req_type),
    .i_res_valid (o_valid),
    .i_res_stall (i_stall),
    .i_status    (o_status),
    .i_read_x    (o_read_x),
    .i_read_y    (o_read_y),
    .i_count     (o_count)
);

`default_nettype wire

// File: tb/sv/positional_point_list_tb.sv
// Self-checking testbench for the positional point list.
// Depends on ppl_pkg for the request and status codes and on the list RTL.
`default_nettype none

module positional_point_list_tb;

    import ppl_pkg::*;

    localparam int LIST_CAP = DEF_CAPACITY;
    localparam int POS_MAX  = (1 << POS_W) - 1;
    localparam int RANDOM_REQUESTS = 850;
    // Request kinds 5 to 7 are not decoded; the block answers them with done.
    localparam logic [REQ_W-1:0] REQ_UNUSED_LO = 3'd5;
    localparam logic [REQ_W-1:0] REQ_UNUSED_HI = 3'd7;

    typedef struct packed {
        logic [REQ_W-1:0]       kind;
        logic [POS_W-1:0]       pos;
        logic signed [PT_W-1:0] x;
        logic signed [PT_W-1:0] y;
    } t_list_request;

    typedef struct packed {
        logic signed [PT_W-1:0] x;
        logic signed [PT_W-1:0] y;
    } t_point;

    typedef struct packed {
        t_status                status;
        logic signed [PT_W-1:0] x;
        logic signed [PT_W-1:0] y;
        logic [COUNT_W-1:0]     count;
    } t_list_answer;

    // Clock, reset and every block input start at known values.
    logic                   i_clk      = 1'b0;
    logic                   i_rst_n    = 1'b0;
    logic                   i_valid    = 1'b0;
    logic [REQ_W-1:0]       i_req_type = REQ_APPEND;
    logic [POS_W-1:0]       i_position = '0;
    logic signed [PT_W-1:0] i_point_x  = '0;
    logic signed [PT_W-1:0] i_point_y  = '0;
    logic                   i_stall    = 1'b0;
    logic                   o_stall;
    logic                   o_valid;
    logic [STATUS_W-1:0]    o_status;
    logic signed [PT_W-1:0] o_read_x;
    logic signed [PT_W-1:0] o_read_y;
    logic [COUNT_W-1:0]     o_count;

    positional_point_list i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_req_type (i_req_type),
        .i_position (i_position),
        .i_point_x  (i_point_x),
        .i_point_y  (i_point_y),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_status   (o_status),
        .o_read_x   (o_read_x),
        .o_read_y   (o_read_y),
        .o_count    (o_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Requests waiting to be driven, and the answers the list owes us.
    t_list_request pending_requests[$];
    t_list_answer  owed_answers[$];
    // Our own copy of the list contents, oldest position first.
    t_point        shadow_list[$];

    int  mismatch_count = 0;
    bit  req_taken      = 1'b0;

    // Stimulus shaping keeps a rough idea of the list length so that most
    // positions land inside the list and grow phases actually fill it.
    int  planned_len    = 0;
    int  planned_count  = 0;

    // Sender burst and gap bookkeeping, and the receiver's stall run.
    int  burst_left     = 0;
    int  gap_left       = 0;
    int  stall_hold     = 0;

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // Works out what the list must answer for one accepted request and
    // updates the shadow contents the same way the hardware shifts its cells.
    function automatic t_list_answer apply_list_request(input t_list_request req);
        t_list_answer ans;
        t_point       pt;
        ans.status = STATUS_DONE;
        ans.x      = '0;
        ans.y      = '0;
        pt.x       = req.x;
        pt.y       = req.y;
        case (req.kind)
            REQ_APPEND: begin
                if (shadow_list.size() >= LIST_CAP) ans.status = STATUS_FULL;
                else shadow_list.insert(shadow_list.size(), pt);
            end
            REQ_INSERT: begin
                // A position past the end is rejected before fullness is looked at.
                if (req.pos > shadow_list.size()) ans.status = STATUS_BAD_POS;
                else if (shadow_list.size() >= LIST_CAP) ans.status = STATUS_FULL;
                else shadow_list.insert(req.pos, pt);
            end
            REQ_REMOVE: begin
                if (req.pos >= shadow_list.size()) ans.status = STATUS_BAD_POS;
                else shadow_list.delete(req.pos);
            end
            REQ_CLEAR: begin
                shadow_list.delete();
            end
            REQ_READ: begin
                if (req.pos >= shadow_list.size()) begin
                    ans.status = STATUS_BAD_POS;
                end else begin
                    ans.x = shadow_list[req.pos].x;
                    ans.y = shadow_list[req.pos].y;
                end
            end
            default: ;
        endcase
        ans.count = COUNT_W'(shadow_list.size());
        return ans;
    endfunction

    // Queues one request and tracks the planned length for position picking.
    task automatic queue_request(input logic [REQ_W-1:0] kind, input int pos,
                                 input logic signed [PT_W-1:0] x,
                                 input logic signed [PT_W-1:0] y);
        t_list_request req;
        req.kind = kind;
        req.pos  = POS_W'(pos);
        req.x    = x;
        req.y    = y;
        pending_requests.insert(pending_requests.size(), req);
        case (kind)
            REQ_APPEND: if (planned_len < LIST_CAP) planned_len++;
            REQ_INSERT: if (pos <= planned_len && planned_len < LIST_CAP) planned_len++;
            REQ_REMOVE: if (pos < planned_len) planned_len--;
            REQ_CLEAR:  planned_len = 0;
            default: ;
        endcase
        // Requests the list merely ignores do not count toward the total.
        if (kind <= REQ_READ) planned_count++;
    endtask

    function automatic logic signed [PT_W-1:0] rand_coord();
        if ($urandom_range(0, 7) != 0) return PT_W'($urandom());
        case ($urandom_range(0, 3))
            0:       return 16'sh8000;
            1:       return 16'sh7fff;
            2:       return 16'sh0000;
            default: return -16'sd1;
        endcase
    endfunction

    // Mostly a position in 0..top; now and then one past it, up to the
    // largest value the field can carry. An empty range forces the latter.
    function automatic int pick_pos(input int top);
        if (top < 0 || $urandom_range(0, 9) == 0) return $urandom_range(top + 1, POS_MAX);
        return $urandom_range(0, top);
    endfunction

    task automatic queue_directed();
        // Everything on an empty list is out of range.
        queue_request(REQ_READ,   0, 16'sd0, 16'sd0);
        queue_request(REQ_REMOVE, 0, 16'sd0, 16'sd0);
        queue_request(REQ_INSERT, 1, 16'sd0, 16'sd0);
        // Coordinate extremes, then inserts at the front, at the end and past the end.
        queue_request(REQ_APPEND, 0, 16'sh8000, 16'sh7fff);
        queue_request(REQ_APPEND, 0, 16'sh7fff, 16'sh8000);
        queue_request(REQ_INSERT, 0, 16'sh0000, -16'sd1);
        queue_request(REQ_INSERT, 3, 16'sh5555, 16'shaaaa);
        queue_request(REQ_INSERT, 5, 16'sh1234, 16'sh4321);
        for (int p = 0; p < 4; p++) queue_request(REQ_READ, p, 16'sd0, 16'sd0);
        // Reads at the count and at the top of the position field.
        queue_request(REQ_READ,   4, 16'sd0, 16'sd0);
        queue_request(REQ_READ,   POS_MAX, 16'sd0, 16'sd0);
        queue_request(REQ_REMOVE, 1, 16'sd0, 16'sd0);
        queue_request(REQ_REMOVE, 3, 16'sd0, 16'sd0);
        // Undecoded kinds carry a full payload that must be ignored.
        for (int k = REQ_UNUSED_LO; k <= REQ_UNUSED_HI; k++)
            queue_request(REQ_W'(k), 0, 16'sh7fff, 16'sh7fff);
        queue_request(REQ_READ,   2, 16'sd0, 16'sd0);
        queue_request(REQ_CLEAR,  0, 16'sd0, 16'sd0);
        queue_request(REQ_READ,   0, 16'sd0, 16'sd0);
        queue_request(REQ_APPEND, 0, 16'sh0001, 16'sh8001);
    endtask

    // Random requests come in phases: growing phases push the list to full
    // so the full status shows up, shrinking phases drain it, mixed phases
    // stir the middle, and noise phases throw arbitrary fields at it.
    // The last phase and the ignored kinds bring the total up to the target.
    task automatic queue_random();
        int phase_kind;
        int phase_len;
        int pick;
        bit first_phase;
        first_phase = 1'b1;
        while (planned_count < RANDOM_REQUESTS - 90) begin
            pick       = $urandom_range(0, 9);
            phase_kind = first_phase ? 0 : (pick < 4) ? 0 : (pick < 7) ? 1 : (pick < 9) ? 2 : 3;
            phase_len  = first_phase ? 90 : $urandom_range(10, 90);
            first_phase = 1'b0;
            repeat (phase_len) begin
                pick = $urandom_range(0, 99);
                if (phase_kind == 3 || $urandom_range(0, 24) == 0) begin
                    queue_request(REQ_W'($urandom_range(0, REQ_UNUSED_HI)),
                                  $urandom_range(0, POS_MAX), rand_coord(), rand_coord());
                end else if ((phase_kind == 0 && pick < 45) ||
                             (phase_kind == 1 && pick < 20) ||
                             (phase_kind == 2 && pick < 10)) begin
                    queue_request(REQ_APPEND, $urandom_range(0, POS_MAX),
                                  rand_coord(), rand_coord());
                end else if ((phase_kind == 0 && pick < 80) ||
                             (phase_kind == 1 && pick < 40) ||
                             (phase_kind == 2 && pick < 20)) begin
                    queue_request(REQ_INSERT, pick_pos(planned_len), rand_coord(), rand_coord());
                end else if ((phase_kind == 0 && pick < 90) ||
                             (phase_kind == 1 && pick < 65) ||
                             (phase_kind == 2 && pick < 45)) begin
                    queue_request(REQ_READ, pick_pos(planned_len - 1),
                                  rand_coord(), rand_coord());
                end else if (phase_kind == 1 && pick >= 97) begin
                    queue_request(REQ_CLEAR, $urandom_range(0, POS_MAX),
                                  rand_coord(), rand_coord());
                end else begin
                    queue_request(REQ_REMOVE, pick_pos(planned_len - 1),
                                  rand_coord(), rand_coord());
                end
            end
        end
    endtask

    // Driver: presents a new request at the falling edge once the previous
    // one was taken, in bursts of random length separated by random gaps.
    // A gap of zero strings bursts together into stretches with no idling.
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_valid || req_taken)) begin
            if (gap_left > 0) begin
                gap_left--;
                i_valid <= 1'b0;
            end else if (pending_requests.size() > 0) begin
                i_valid    <= 1'b1;
                i_req_type <= pending_requests[0].kind;
                i_position <= pending_requests[0].pos;
                i_point_x  <= pending_requests[0].x;
                i_point_y  <= pending_requests[0].y;
                void'(pending_requests.pop_front());
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Result side: alternates stall runs with free runs; free runs are now
    // and then long so results also drain back to back.
    always @(negedge i_clk) begin
        if (stall_hold > 0) begin
            stall_hold--;
        end else begin
            i_stall    <= !i_stall;
            stall_hold = !i_stall ? $urandom_range(0, 7)
                       : ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 5);
        end
    end

    // Monitor: at each rising edge, checks a result that is handed over and
    // predicts the answer to a request that is accepted.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_taken <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (owed_answers.size() == 0) begin
                    report_mismatch("result with no request outstanding");
                end else begin
                    t_list_answer want;
                    want = owed_answers.pop_front();
                    if (o_status !== want.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  o_status, want.status));
                    if (o_read_x !== want.x)
                        report_mismatch($sformatf("read_x %0d, expected %0d",
                                                  o_read_x, want.x));
                    if (o_read_y !== want.y)
                        report_mismatch($sformatf("read_y %0d, expected %0d",
                                                  o_read_y, want.y));
                    if (o_count !== want.count)
                        report_mismatch($sformatf("count %0d, expected %0d",
                                                  o_count, want.count));
                end
            end
            req_taken <= i_valid && !o_stall;
            if (i_valid && !o_stall) begin
                t_list_request got;
                got.kind = i_req_type;
                got.pos  = i_position;
                got.x    = i_point_x;
                got.y    = i_point_y;
                owed_answers.insert(owed_answers.size(), apply_list_request(got));
            end
        end
    end

    // Main sequence: build the stimulus, reset once, then wait for every
    // request to be sent and every answer to be collected.
    initial begin
        queue_directed();
        queue_random();
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        while (pending_requests.size() != 0 || i_valid) @(posedge i_clk);
        while (owed_answers.size() != 0) @(posedge i_clk);
        // Waiting on afterwards catches any stray result.
        repeat (8) @(posedge i_clk);
        if (owed_answers.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", owed_answers.size()));
        if (mismatch_count == 0) begin
            $display("PASS positional_point_list");
        end else begin
            $display("FAIL positional_point_list");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run of about 900 requests,
    // each waiting out the longest gap and the longest stall.
    initial begin
        #2000000;
        $display("FAIL positional_point_list");
        $finish;
    end

endmodule

`default_nettype wire
